/* src/lph_pkg.sv */
// lph_pkg: shared constants, codes and controller/datapath interface types
// for the projection hash block. No dependencies.
`timescale 1ns / 1ps

package lph_pkg;

  localparam int MAX_GROUPS_DEF = 16;
  localparam int MAX_FUNCS_DEF  = 8;
  localparam int MAX_DIMS_DEF   = 64;

  localparam int VAL_W   = 16;  // coefficient, weight and data width
  localparam int ACC_W   = 48;  // dot-product accumulator, Q.22
  localparam int BW_W    = 32;  // bucket width
  localparam int QUOT_W  = 49;  // signed bucket number
  localparam int WPROD_W = 65;  // bucket number times weight
  localparam int SUM_W   = 68;  // exact weighted sum

  localparam logic [BW_W-1:0] BUCKET_WIDTH_RST = 32'd4194304;
  localparam logic [4:0]      GROUPS_RST       = 5'd16;
  localparam logic [3:0]      FUNCS_RST        = 4'd8;

  typedef enum logic [1:0] {
    REG_BUCKET_WIDTH = 2'd0,
    REG_GROUPS       = 2'd1,
    REG_FUNCS        = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    REQ_COEF   = 2'd0,
    REQ_WEIGHT = 2'd1,
    REQ_DATA   = 2'd2
  } req_type_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHECK, ST_MAC, ST_DRAIN, ST_FIN, ST_GRP, ST_RD,
    ST_DIVST, ST_DIVW, ST_MUL, ST_ADD, ST_EMIT, ST_CLEAR
  } ctrl_state_t;

  typedef struct packed {
    logic capture;
    logic load;
    logic cnt_clr;
    logic mac_issue;
    logic sum_clr;
    logic div_start;
    logic mul;
    logic add;
    logic func_inc;
    logic group_inc;
    logic emit;
    logic acc_clear;
  } lph_cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       dim_ok;
    logic       last_dim;
    logic       ng_zero;
    logic       nf_zero;
    logic       mac_last;
    logic       last_func;
    logic       last_group;
    logic       pipe_busy;
    logic       div_done;
    logic       out_free;
  } lph_status_t;

endpackage

/* src/lph_div.sv */
// lph_div: restoring divider, one quotient bit per cycle, floor rounding
// of a signed dividend by an unsigned non-zero divisor. Uses no package.
`timescale 1ns / 1ps

module lph_div #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] num,
  input  logic        [DEN_W-1:0] den,
  output logic                    done,
  output logic signed [NUM_W:0]   quot
);

  localparam int CW = $clog2(NUM_W + 1);

  logic             busy_r, fix_r, done_r, neg_r;
  logic [CW-1:0]    cnt_r;
  logic [NUM_W-1:0] dvd_r;
  logic [DEN_W-1:0] rem_r, den_r;
  logic signed [NUM_W:0] quot_r;

  logic [DEN_W:0]   rem_sh, rem_dif;
  logic             ge;
  logic [NUM_W:0]   qmag;

  assign rem_sh  = {rem_r, dvd_r[NUM_W-1]};
  assign rem_dif = rem_sh - {1'b0, den_r};
  assign ge      = rem_sh >= {1'b0, den_r};
  assign qmag    = {1'b0, dvd_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fix_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      fix_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= CW'(NUM_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
        fix_r  <= 1'b1;
      end
    end else if (fix_r) begin
      fix_r  <= 1'b0;
      done_r <= 1'b1;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= num[NUM_W-1];
      dvd_r <= num[NUM_W-1] ? (~num + NUM_W'(1)) : num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= ge ? rem_dif[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      dvd_r <= {dvd_r[NUM_W-2:0], ge};
    end else if (fix_r) begin
      // floor towards minus infinity for a negative dividend
      if (neg_r)
        quot_r <= -$signed(qmag) - ((rem_r != '0) ? (NUM_W+1)'(1) : (NUM_W+1)'(0));
      else
        quot_r <= $signed(qmag);
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

/* src/lph_ctrl.sv */
// lph_ctrl: sequencer for loads, the shared multiply-accumulate sweep and
// the per-group hash combine. Depends on lph_pkg.
`timescale 1ns / 1ps

module lph_ctrl
  import lph_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  lph_status_t sts,
  output lph_cmd_t    cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.load  = 1'b1;
        state_nxt = ST_IDLE;
        if (sts.req_type == REQ_DATA) begin
          if (sts.dim_ok && !sts.ng_zero && !sts.nf_zero) begin
            cmd.cnt_clr = 1'b1;
            state_nxt   = ST_MAC;
          end else if (sts.last_dim) begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_MAC: begin
        cmd.mac_issue = 1'b1;
        if (sts.mac_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) state_nxt = sts.last_dim ? ST_FIN : ST_IDLE;
      end
      ST_FIN: begin
        cmd.cnt_clr = 1'b1;
        state_nxt   = sts.ng_zero ? ST_CLEAR : ST_GRP;
      end
      ST_GRP: begin
        cmd.sum_clr = 1'b1;
        state_nxt   = sts.nf_zero ? ST_EMIT : ST_RD;
      end
      ST_RD:    state_nxt = ST_DIVST;
      ST_DIVST: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIVW;
      end
      ST_DIVW: begin
        if (sts.div_done) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        cmd.add = 1'b1;
        if (sts.last_func) begin
          state_nxt = ST_EMIT;
        end else begin
          cmd.func_inc = 1'b1;
          state_nxt    = ST_RD;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.last_group) begin
            state_nxt = ST_CLEAR;
          end else begin
            cmd.group_inc = 1'b1;
            state_nxt     = ST_GRP;
          end
        end
      end
      ST_CLEAR: begin
        cmd.acc_clear = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

/* src/lph_datapath.sv */
// lph_datapath: coefficient store, weights, accumulator memory, the MAC
// pipeline, divider, weighted-sum combine and the result register.
// Depends on lph_pkg and lph_div.
`timescale 1ns / 1ps

module lph_datapath
  import lph_pkg::*;
#(
  parameter int MAX_GROUPS = MAX_GROUPS_DEF,
  parameter int MAX_FUNCS  = MAX_FUNCS_DEF,
  parameter int MAX_DIMS   = MAX_DIMS_DEF,
  parameter int CGW        = $clog2(MAX_GROUPS + 1),
  parameter int CFW        = $clog2(MAX_FUNCS + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  lph_cmd_t                cmd,
  output lph_status_t             sts,
  input  logic [1:0]              in_req_type,
  input  logic [3:0]              in_group_index,
  input  logic [2:0]              in_func_index,
  input  logic [5:0]              in_dim_index,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic                    in_last_dim,
  input  logic [CGW-1:0]          ng,
  input  logic [CFW-1:0]          nf,
  input  logic [BW_W-1:0]         bucket_w,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [ACC_W-1:0] out_hash,
  output logic [3:0]              out_group,
  output logic                    out_last
);

  localparam int NACC = MAX_GROUPS * MAX_FUNCS;
  localparam int NPRJ = NACC * MAX_DIMS;
  localparam int AW   = (NACC > 1) ? $clog2(NACC) : 1;
  localparam int PW   = (NPRJ > 1) ? $clog2(NPRJ) : 1;
  localparam int FW   = (MAX_FUNCS > 1) ? $clog2(MAX_FUNCS) : 1;

  localparam logic signed [ACC_W:0] MAC_HI = {2'b00, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W:0] MAC_LO = ~MAC_HI;
  localparam logic signed [SUM_W-1:0] SUM_HI = {{(SUM_W-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_LO = ~SUM_HI;

  // captured item
  logic [1:0]              type_r;
  logic [3:0]              g_r;
  logic [2:0]              f_r;
  logic [5:0]              d_r;
  logic signed [VAL_W-1:0] val_r;
  logic                    last_r;

  logic g_ok, f_ok, d_ok;
  assign g_ok = 32'(g_r) < MAX_GROUPS;
  assign f_ok = 32'(f_r) < MAX_FUNCS;
  assign d_ok = 32'(d_r) < MAX_DIMS;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      type_r <= in_req_type;
      g_r    <= in_group_index;
      f_r    <= in_func_index;
      d_r    <= in_dim_index;
      val_r  <= in_value;
      last_r <= in_last_dim;
    end
  end

  // group / function counters
  logic [CGW-1:0] gi_r;
  logic [CFW-1:0] fi_r;
  logic           last_func, last_group;

  assign last_func  = fi_r == nf - CFW'(1);
  assign last_group = gi_r == ng - CGW'(1);

  always_ff @(posedge clk) begin
    if (cmd.cnt_clr) begin
      gi_r <= '0;
      fi_r <= '0;
    end else if (cmd.group_inc) begin
      gi_r <= gi_r + CGW'(1);
      fi_r <= '0;
    end else if (cmd.mac_issue || cmd.func_inc) begin
      if (last_func) begin
        fi_r <= '0;
        gi_r <= gi_r + CGW'(1);
      end else begin
        fi_r <= fi_r + CFW'(1);
      end
    end
  end

  logic [AW-1:0] acc_addr;
  logic [PW-1:0] prj_raddr, prj_waddr;
  assign acc_addr  = AW'(32'(gi_r) * MAX_FUNCS + 32'(fi_r));
  assign prj_raddr = PW'((32'(gi_r) * MAX_FUNCS + 32'(fi_r)) * MAX_DIMS + 32'(d_r));
  assign prj_waddr = PW'((32'(g_r) * MAX_FUNCS + 32'(f_r)) * MAX_DIMS + 32'(d_r));

  // coefficient store
  logic signed [VAL_W-1:0] prj_mem [0:NPRJ-1];
  logic signed [VAL_W-1:0] coef_q_r;

  always_ff @(posedge clk) begin
    if (cmd.load && type_r == REQ_COEF && g_ok && f_ok && d_ok)
      prj_mem[prj_waddr] <= val_r;
    coef_q_r <= prj_mem[prj_raddr];
  end

  // combining weights
  logic signed [VAL_W-1:0] wgt_r [0:MAX_FUNCS-1];

  always_ff @(posedge clk) begin
    if (cmd.load && type_r == REQ_WEIGHT && f_ok)
      wgt_r[FW'(32'(f_r))] <= val_r;
  end

  // accumulator memory, entries not valid read as zero
  logic signed [ACC_W-1:0] acc_mem [0:NACC-1];
  logic [NACC-1:0]         acc_vld_r;
  logic signed [ACC_W-1:0] acc_rd_r;
  logic                    acc_rv_r;
  logic signed [ACC_W-1:0] acc_q;

  logic                    v1_r, v2_r;
  logic [AW-1:0]           a1_r, a2_r;
  logic signed [31:0]      prod_r;
  logic signed [ACC_W-1:0] acc2_r;
  logic signed [ACC_W:0]   mac_sum;
  logic signed [ACC_W-1:0] mac_sat;

  assign acc_q   = acc_rv_r ? acc_rd_r : '0;
  assign mac_sum = {acc2_r[ACC_W-1], acc2_r} + (ACC_W+1)'(prod_r);
  assign mac_sat = (mac_sum > MAC_HI) ? MAC_HI[ACC_W-1:0] :
                   (mac_sum < MAC_LO) ? MAC_LO[ACC_W-1:0] : mac_sum[ACC_W-1:0];

  always_ff @(posedge clk) begin
    acc_rd_r <= acc_mem[acc_addr];
    if (v2_r) acc_mem[a2_r] <= mac_sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_vld_r <= '0;
      acc_rv_r  <= 1'b0;
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
    end else begin
      acc_rv_r <= acc_vld_r[acc_addr];
      if (cmd.acc_clear)  acc_vld_r       <= '0;
      else if (v2_r)      acc_vld_r[a2_r] <= 1'b1;
      v1_r <= cmd.mac_issue;
      v2_r <= v1_r;
    end
  end

  // mac pipeline: read, multiply, add and saturate
  always_ff @(posedge clk) begin
    a1_r   <= acc_addr;
    a2_r   <= a1_r;
    prod_r <= coef_q_r * val_r;
    acc2_r <= acc_q;
  end

  // bucket number, weighted sum
  logic                     div_done;
  logic signed [QUOT_W-1:0] quot;
  logic signed [WPROD_W-1:0] wp_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [ACC_W-1:0]  sum_sat;

  lph_div #(
    .NUM_W (ACC_W),
    .DEN_W (BW_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (acc_q),
    .den   (bucket_w),
    .done  (div_done),
    .quot  (quot)
  );

  assign sum_sat = (sum_r > SUM_HI) ? SUM_HI[ACC_W-1:0] :
                   (sum_r < SUM_LO) ? SUM_LO[ACC_W-1:0] : sum_r[ACC_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.mul) wp_r <= quot * wgt_r[fi_r[FW-1:0]];
    if (cmd.sum_clr)  sum_r <= '0;
    else if (cmd.add) sum_r <= sum_r + SUM_W'(wp_r);
  end

  // result register
  logic                    out_valid_r;
  logic signed [ACC_W-1:0] out_hash_r;
  logic [3:0]              out_group_r;
  logic                    out_last_r;
  logic [31:0]             gi_ext;

  assign gi_ext = 32'(gi_r);

  always_ff @(posedge clk) begin
    if (!rst_n)            out_valid_r <= 1'b0;
    else if (cmd.emit)     out_valid_r <= 1'b1;
    else if (out_ready)    out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_hash_r  <= sum_sat;
      out_group_r <= gi_ext[3:0];
      out_last_r  <= last_group;
    end
  end

  assign out_valid = out_valid_r;
  assign out_hash  = out_hash_r;
  assign out_group = out_group_r;
  assign out_last  = out_last_r;

  always_comb begin
    sts            = '0;
    sts.req_type   = type_r;
    sts.dim_ok     = d_ok;
    sts.last_dim   = last_r;
    sts.ng_zero    = ng == '0;
    sts.nf_zero    = nf == '0;
    sts.mac_last   = last_func && last_group;
    sts.last_func  = last_func;
    sts.last_group = last_group;
    sts.pipe_busy  = v1_r || v2_r;
    sts.div_done   = div_done;
    sts.out_free   = !out_valid_r || out_ready;
  end

endmodule

/* src/lsh_projection_hash_top.sv */
// lsh_projection_hash_top: Euclidean p-stable LSH hash block, register
// port and stream channels. Depends on lph_pkg, lph_ctrl, lph_datapath.
//
//  channel  | ports                          | item
//  ---------+--------------------------------+-----------------------------------
//  in       | in_tvalid/tready/tdata/tuser/  | coefficient, weight or data element
//           | tlast                          |
//  out      | out_tvalid/tready/tdata/tlast  | one group hash
//  cfg      | cfg_psel/penable/pwrite/paddr/ | bucket width, group and func count
//           | pwdata/prdata/pready           |
//
// a load item is captured and then written; a data element is captured, checked,
// then runs one shared multiply-accumulate per group and function (128 at
// defaults) and drains the MAC pipeline; a last element then runs, per group
// and function, the bit-serial bucket divider and the combine, with a set-up
// and an emit step per group, and one step each to start the combine and clear the accumulators
// synchronous active-low reset; accumulators read as zero after reset
// a stalled out channel holds the sequencer at the next group's emit only
`timescale 1ns / 1ps

module lsh_projection_hash_top
  import lph_pkg::*;
#(
  parameter int MAX_GROUPS = MAX_GROUPS_DEF,
  parameter int MAX_FUNCS  = MAX_FUNCS_DEF,
  parameter int MAX_DIMS   = MAX_DIMS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // in channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // group_index[3:0] func_index[6:4] dim_index[12:7] value[28:13]
  input  logic [1:0]  in_tuser,   // req_type
  input  logic        in_tlast,   // last_dim
  // out channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // hash_value[47:0] group_id[51:48]
  output logic        out_tlast,  // last_hash
  // register port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int CGW = $clog2(MAX_GROUPS + 1);
  localparam int CFW = $clog2(MAX_FUNCS + 1);

  // configuration registers
  logic [BW_W-1:0] bucket_width_r;
  logic [4:0]      groups_r;
  logic [3:0]      funcs_r;
  logic            cfg_wr;
  logic [1:0]      cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bucket_width_r <= BUCKET_WIDTH_RST;
      groups_r       <= GROUPS_RST;
      funcs_r        <= FUNCS_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_BUCKET_WIDTH: bucket_width_r <= cfg_pwdata;
        REG_GROUPS:       groups_r       <= cfg_pwdata[4:0];
        REG_FUNCS:        funcs_r        <= cfg_pwdata[3:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_BUCKET_WIDTH: cfg_prdata = bucket_width_r;
      REG_GROUPS:       cfg_prdata = {27'd0, groups_r};
      REG_FUNCS:        cfg_prdata = {28'd0, funcs_r};
      default:          cfg_prdata = '0;
    endcase
  end

  // clamp counts to the built sizes, a zero width counts as the smallest
  logic [CGW-1:0]  ng;
  logic [CFW-1:0]  nf;
  logic [BW_W-1:0] bw_eff;

  assign ng     = (32'(groups_r) > MAX_GROUPS) ? CGW'(MAX_GROUPS) : CGW'(32'(groups_r));
  assign nf     = (32'(funcs_r) > MAX_FUNCS) ? CFW'(MAX_FUNCS) : CFW'(32'(funcs_r));
  assign bw_eff = (bucket_width_r == '0) ? BW_W'(1) : bucket_width_r;

  lph_cmd_t    cmd;
  lph_status_t sts;

  lph_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  logic signed [ACC_W-1:0] hash;
  logic [3:0]              group_id;

  lph_datapath #(
    .MAX_GROUPS (MAX_GROUPS),
    .MAX_FUNCS  (MAX_FUNCS),
    .MAX_DIMS   (MAX_DIMS),
    .CGW        (CGW),
    .CFW        (CFW)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_req_type    (in_tuser),
    .in_group_index (in_tdata[3:0]),
    .in_func_index  (in_tdata[6:4]),
    .in_dim_index   (in_tdata[12:7]),
    .in_value       (in_tdata[28:13]),
    .in_last_dim    (in_tlast),
    .ng             (ng),
    .nf             (nf),
    .bucket_w       (bw_eff),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_hash       (hash),
    .out_group      (group_id),
    .out_last       (out_tlast)
  );

  assign out_tdata = {4'd0, group_id, hash};

endmodule
